/* src/tmd_pkg.sv */
// Shared types and constants for the three-motor drive with command timeout.
// Used by tmd_core and three_motor_drive_with_timeout_unit; no dependencies.
package tmd_pkg;

  localparam int unsigned NumMotors  = 3;
  localparam int unsigned NumLimits  = 2;
  localparam int unsigned PowerW     = 11;
  localparam int unsigned DutyW      = 10;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned CfgIdxW    = 1;

  localparam logic signed [PowerW-1:0] PowerMax = 11'sd1023;
  localparam logic signed [PowerW-1:0] PowerMin = -11'sd1023;
  localparam logic [TimeW-1:0]         TimeoutReset = 32'd500;

  // Item kind carried in the action field.
  typedef enum logic [0:0] {
    ACT_SET_POWER = 1'b0,
    ACT_TICK      = 1'b1
  } action_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIMEOUT_MS  = 1'b0,
    CFG_LEDS_ENABLE = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic               action;
    logic [1:0]         motor_index;
    logic signed [15:0] power;
    logic [TimeW-1:0]   now_ms;
    logic               limit_0_pressed;
    logic               limit_1_pressed;
  } in_t;

  typedef struct packed {
    logic             dir_0;
    logic             dir_1;
    logic             dir_2;
    logic [DutyW-1:0] duty_0;
    logic [DutyW-1:0] duty_1;
    logic [DutyW-1:0] duty_2;
    logic             encoder_reset_0;
    logic             encoder_reset_1;
    logic             debug_flash;
  } out_t;

  // Saturate a 16-bit signed request to the drive range of plus or minus 1023.
  function automatic logic signed [PowerW-1:0] sat_power(input logic signed [15:0] req);
    logic signed [PowerW-1:0] res;
    if (req > 16'(PowerMax)) begin
      res = PowerMax;
    end else if (req < 16'(PowerMin)) begin
      res = PowerMin;
    end else begin
      res = req[PowerW-1:0];
    end
    return res;
  endfunction

endpackage

/* src/three_motor_drive_with_timeout_unit.sv */
// Top level of the three-motor drive with command timeout.
// Depends on tmd_pkg and tmd_core.

// The block accepts one transaction per cycle while no tick is held in the
// input register, and has two register stages: an input transaction is
// captured in an input register and processed from there by tmd_core. A tick's
// result is loaded into the output register once the output side is free,
// which raises out_valid_o. Set-power transactions update the motor state and
// produce no result. The output register can hold the flow: while a result
// waits to be taken, a following set-power transaction still proceeds, but a
// following tick holds in the input register until the output side is free.
// Configuration writes take effect at the next clock edge and must be made
// while no transaction is in flight.
module three_motor_drive_with_timeout_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  tmd_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tmd_pkg::out_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  logic [tmd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tmd_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import tmd_pkg::*;

  logic             in_valid_q;
  in_t              in_data_q;
  logic             out_valid_q;
  out_t             out_data_q;
  logic [TimeW-1:0] timeout_q;
  logic             leds_en_q;

  logic             s1_is_tick;
  logic             out_free;
  logic             s1_advance;
  out_t             result;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
      leds_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TIMEOUT_MS:  timeout_q <= cfg_wdata_i[TimeW-1:0];
        CFG_LEDS_ENABLE: leds_en_q <= cfg_wdata_i[0];
        default:         ;
      endcase
    end
  end

  // Pipeline flow control.
  assign s1_is_tick = (action_e'(in_data_q.action) == ACT_TICK);
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_advance = in_valid_q && (!s1_is_tick || out_free);
  assign in_ready_o = !in_valid_q || s1_advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  tmd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (s1_advance),
    .item_i        (in_data_q),
    .timeout_ms_i  (timeout_q),
    .leds_enable_i (leds_en_q),
    .result_o      (result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_advance && s1_is_tick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_advance && s1_is_tick) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* src/tmd_core.sv */
// Motor state and per-transaction datapath: stored powers, update stamps,
// timeout check and duty/limit-stop decode. Depends on tmd_pkg.
module tmd_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  tmd_pkg::in_t                   item_i,
  input  logic [tmd_pkg::TimeW-1:0]      timeout_ms_i,
  input  logic                           leds_enable_i,
  output tmd_pkg::out_t                  result_o
);
  import tmd_pkg::*;

  logic signed [PowerW-1:0] power_q [NumMotors];
  logic signed [PowerW-1:0] power_d [NumMotors];
  logic [TimeW-1:0]         stamp_q [NumMotors];
  logic [TimeW-1:0]         stamp_d [NumMotors];

  logic signed [PowerW-1:0] eff_power [NumMotors];
  logic [NumMotors-1:0]     dir;
  logic [DutyW-1:0]         duty [NumMotors];
  logic [NumLimits-1:0]     enc_reset;
  logic [NumLimits-1:0]     limit;
  logic [TimeW-1:0]         age;
  logic signed [PowerW-1:0] sat_req;
  logic                     is_tick;

  assign limit   = {item_i.limit_1_pressed, item_i.limit_0_pressed};
  assign sat_req = sat_power(item_i.power);

  always_comb begin
    case (action_e'(item_i.action))
      ACT_TICK:      is_tick = 1'b1;
      ACT_SET_POWER: is_tick = 1'b0;
      default:       is_tick = 1'b0;
    endcase
  end

  // Timeout, next state and drive decode for each motor.
  always_comb begin
    enc_reset = '0;
    for (int m = 0; m < NumMotors; m++) begin
      age          = item_i.now_ms - stamp_q[m];
      eff_power[m] = (age > timeout_ms_i) ? '0 : power_q[m];
      power_d[m]   = power_q[m];
      stamp_d[m]   = stamp_q[m];
      if (is_tick) begin
        power_d[m] = eff_power[m];
      end else if (item_i.motor_index == 2'(m)) begin
        power_d[m] = sat_req;
        stamp_d[m] = item_i.now_ms;
      end
      dir[m]  = eff_power[m][PowerW-1];
      duty[m] = dir[m] ? DutyW'(-eff_power[m]) : eff_power[m][DutyW-1:0];
      if (m < NumLimits) begin
        if (dir[m] && limit[m]) begin
          enc_reset[m] = 1'b1;
          duty[m]      = '0;
        end
      end
    end
  end

  // Motor state registers, cleared on reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < NumMotors; m++) begin
        power_q[m] <= '0;
        stamp_q[m] <= '0;
      end
    end else if (en_i) begin
      for (int m = 0; m < NumMotors; m++) begin
        power_q[m] <= power_d[m];
        stamp_q[m] <= stamp_d[m];
      end
    end
  end

  always_comb begin
    result_o.dir_0           = dir[0];
    result_o.dir_1           = dir[1];
    result_o.dir_2           = dir[2];
    result_o.duty_0          = duty[0];
    result_o.duty_1          = duty[1];
    result_o.duty_2          = duty[2];
    result_o.encoder_reset_0 = enc_reset[0];
    result_o.encoder_reset_1 = enc_reset[1];
    result_o.debug_flash     = leds_enable_i && (|enc_reset);
  end

endmodule
